// ===== rtl/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// Shared codes, constants and control/status bundles for the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd3;

    // key fold shifts for the bucket hash
    localparam int HASH_SHIFT_HI = 16;
    localparam int HASH_SHIFT_LO = 8;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_LINK,
        RD_FREE
    } rd_sel_t;

    typedef struct packed {
        logic                clr_step;
        logic                load;
        logic                hash_step;
        logic                head_rd;
        logic                head_load;
        logic                ent_rd;
        rd_sel_t             rd_sel;
        logic                advance;
        logic                update_val;
        logic                unlink_prev;
        logic                unlink_head;
        logic                push_free;
        logic                alloc_free;
        logic                alloc_fresh;
        logic                write_new;
        logic                resp;
        logic [STATUS_W-1:0] resp_status;
    } cmd_t;

    typedef struct packed {
        logic            ignored;
        logic            hash_done;
        logic            head_ok;
        logic            key_match;
        logic            link_ok;
        logic            prev_ok;
        logic            free_ok;
        logic            fresh_ok;
        logic            out_free;
        logic            clr_last;
        logic [OP_W-1:0] op;
    } sts_t;

endpackage

// ===== rtl/chm_datapath.sv =====
// ----------------------------------------------------------------------------
// chm_datapath
// Bucket head and entry memories, chain walk pointers, free list, hash unit
// and the registered result beat.
// ----------------------------------------------------------------------------
module chm_datapath #(
    parameter int BUCKET_COUNT = 256,
    parameter int POOL_ENTRIES = 1024,
    parameter int KEY_BITS     = 48,
    parameter int VALUE_BITS   = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  chm_pkg::cmd_t                 cmd,
    output chm_pkg::sts_t                 sts,
    input  logic [chm_pkg::OP_W-1:0]      s_operation,
    input  logic [KEY_BITS-1:0]           s_key,
    input  logic [VALUE_BITS-1:0]         s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [chm_pkg::STATUS_W-1:0]  m_status,
    output logic [VALUE_BITS-1:0]         m_found_value
);

    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

    logic [chm_pkg::OP_W-1:0] op_reg;
    logic [KEY_BITS-1:0]      key_reg;
    logic [VALUE_BITS-1:0]    value_reg;
    logic [BKT_W-1:0]         bucket;
    logic                     hash_done;

    logic [LINK_W-1:0]        head_mem [BUCKET_COUNT];
    logic [KEY_BITS-1:0]      key_mem [POOL_ENTRIES];
    logic [VALUE_BITS-1:0]    value_mem [POOL_ENTRIES];
    logic [LINK_W-1:0]        link_mem [POOL_ENTRIES];

    logic [LINK_W-1:0]        head_rd_reg;
    logic [KEY_BITS-1:0]      key_rd_reg;
    logic [VALUE_BITS-1:0]    value_rd_reg;
    logic [LINK_W-1:0]        link_rd_reg;

    logic [LINK_W-1:0]        cur_reg;
    logic [LINK_W-1:0]        prev_reg;
    logic [LINK_W-1:0]        free_head_reg;
    logic [LINK_W-1:0]        fresh_used_reg;
    logic [BKT_W-1:0]         clr_cnt_reg;

    logic                     m_valid_reg;
    logic [chm_pkg::STATUS_W-1:0] m_status_reg;
    logic [VALUE_BITS-1:0]    m_found_value_reg;

    logic [KEY_BITS-1:0]      fold1;
    logic [KEY_BITS-1:0]      fold2;
    logic [LINK_W-1:0]        rd_link;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         cur_idx;
    logic                     link_we;
    logic [IDX_W-1:0]         link_waddr;
    logic [LINK_W-1:0]        link_wdata;
    logic                     head_we;
    logic [BKT_W-1:0]         head_waddr;
    logic [LINK_W-1:0]        head_wdata;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
    end

    // key fold
    assign fold1 = s_key ^ (s_key >> chm_pkg::HASH_SHIFT_HI);
    assign fold2 = fold1 ^ (fold1 >> chm_pkg::HASH_SHIFT_LO);

    generate
        if (BUCKET_COUNT == (1 << BKT_W)) begin : g_mask
            logic [BKT_W-1:0] bucket_reg;

            always_ff @(posedge aclk) begin
                if (cmd.load) begin
                    bucket_reg <= fold2[BKT_W-1:0];
                end
            end

            assign bucket    = bucket_reg;
            assign hash_done = 1'b1;
        end else begin : g_rem
            localparam int CHUNK_W = 8;
            localparam int CHUNKS  = (KEY_BITS + CHUNK_W - 1) / CHUNK_W;
            localparam int HW      = CHUNKS * CHUNK_W;
            localparam int XW      = BKT_W + CHUNK_W;
            localparam int CNT_W   = $clog2(2 * CHUNKS + 1);
            localparam logic [XW-1:0] BKT_X = XW'(BUCKET_COUNT);
            localparam logic [XW-1:0] RECIP = XW'((1 << XW) / BUCKET_COUNT);
            logic [HW-1:0]      h_reg;
            logic [BKT_W-1:0]   rem_reg;
            logic [CNT_W-1:0]   cnt_reg;
            logic [XW-1:0]      x_reg;
            logic [CHUNK_W-1:0] q_reg;
            logic [XW-1:0]      x_cur;
            logic [2*XW-1:0]    prod;
            logic [2*XW-1:0]    qb;
            logic [XW-1:0]      r_raw;
            logic [XW-1:0]      r_fix;

            // remainder a byte at a time: quotient estimate, then subtract and fix up
            assign x_cur = {rem_reg, h_reg[HW-1 -: CHUNK_W]};
            assign prod  = {{XW{1'b0}}, x_cur} * {{XW{1'b0}}, RECIP};
            assign qb    = {{XW{1'b0}}, {{BKT_W{1'b0}}, q_reg}} * {{XW{1'b0}}, BKT_X};
            assign r_raw = x_reg - qb[XW-1:0];
            assign r_fix = (r_raw >= BKT_X) ? (r_raw - BKT_X) : r_raw;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cnt_reg <= '0;
                end else if (cmd.load) begin
                    cnt_reg <= CNT_W'(2 * CHUNKS);
                end else if (cmd.hash_step && cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (cmd.load) begin
                    h_reg   <= HW'(fold2);
                    rem_reg <= '0;
                end else if (cmd.hash_step && cnt_reg != '0) begin
                    if (!cnt_reg[0]) begin
                        x_reg <= x_cur;
                        q_reg <= prod[XW+CHUNK_W-1:XW];
                    end else begin
                        rem_reg <= r_fix[BKT_W-1:0];
                        h_reg   <= h_reg << CHUNK_W;
                    end
                end
            end

            assign bucket    = rem_reg;
            assign hash_done = (cnt_reg == '0);
        end
    endgenerate

    // entry read address
    always_comb begin
        case (cmd.rd_sel)
            chm_pkg::RD_LINK: rd_link = link_rd_reg;
            chm_pkg::RD_FREE: rd_link = free_head_reg;
            default:          rd_link = head_rd_reg;
        endcase
    end

    assign rd_idx  = rd_link[IDX_W-1:0];
    assign cur_idx = cur_reg[IDX_W-1:0];

    // bucket head memory
    assign head_we    = cmd.clr_step || cmd.unlink_head || cmd.write_new;
    assign head_waddr = cmd.clr_step ? clr_cnt_reg : bucket;
    assign head_wdata = cmd.clr_step ? NIL : (cmd.unlink_head ? link_rd_reg : cur_reg);

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (cmd.head_rd) begin
            head_rd_reg <= head_mem[bucket];
        end
    end

    // entry memories
    always_ff @(posedge aclk) begin
        if (cmd.write_new) begin
            key_mem[cur_idx] <= key_reg;
        end
        if (cmd.ent_rd) begin
            key_rd_reg <= key_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update_val || cmd.write_new) begin
            value_mem[cur_idx] <= value_reg;
        end
        if (cmd.ent_rd) begin
            value_rd_reg <= value_mem[rd_idx];
        end
    end

    assign link_we    = cmd.unlink_prev || cmd.push_free || cmd.write_new;
    assign link_waddr = cmd.unlink_prev ? prev_reg[IDX_W-1:0] : cur_idx;
    assign link_wdata = cmd.unlink_prev ? link_rd_reg :
                        (cmd.push_free ? free_head_reg : head_rd_reg);

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.ent_rd) begin
            link_rd_reg <= link_mem[rd_idx];
        end
    end

    // walk pointers
    always_ff @(posedge aclk) begin
        if (cmd.head_load) begin
            cur_reg  <= head_rd_reg;
            prev_reg <= NIL;
        end else if (cmd.advance) begin
            cur_reg  <= link_rd_reg;
            prev_reg <= cur_reg;
        end else if (cmd.alloc_free) begin
            cur_reg <= free_head_reg;
        end else if (cmd.alloc_fresh) begin
            cur_reg <= fresh_used_reg;
        end
    end

    // free list, fresh pool count, head clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= NIL;
            fresh_used_reg <= '0;
            clr_cnt_reg    <= '0;
        end else begin
            if (cmd.push_free) begin
                free_head_reg <= cur_reg;
            end else if (cmd.alloc_free) begin
                free_head_reg <= link_rd_reg;
            end
            if (cmd.alloc_fresh) begin
                fresh_used_reg <= fresh_used_reg + 1'b1;
            end
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.resp) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp) begin
            m_status_reg <= cmd.resp_status;
            if (cmd.resp_status == chm_pkg::STATUS_DONE && op_reg == chm_pkg::OP_LOOKUP) begin
                m_found_value_reg <= value_rd_reg;
            end else begin
                m_found_value_reg <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_value_reg;

    // status to controller
    assign sts.ignored   = (key_reg == '0) || (op_reg == chm_pkg::OP_RESERVED) ||
                           (op_reg == chm_pkg::OP_INSERT && value_reg == '0);
    assign sts.hash_done = hash_done;
    assign sts.head_ok   = (head_rd_reg < NIL);
    assign sts.key_match = (key_rd_reg == key_reg);
    assign sts.link_ok   = (link_rd_reg < NIL);
    assign sts.prev_ok   = (prev_reg < NIL);
    assign sts.free_ok   = (free_head_reg < NIL);
    assign sts.fresh_ok  = (fresh_used_reg < NIL);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.clr_last  = (clr_cnt_reg == BKT_W'(BUCKET_COUNT - 1));
    assign sts.op        = op_reg;

endmodule

// ===== rtl/chm_controller.sv =====
// ----------------------------------------------------------------------------
// chm_controller
// Sequencer for head clearing, hashing, chain walk and list updates.
// ----------------------------------------------------------------------------
module chm_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  chm_pkg::sts_t sts,
    output chm_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_CMP,
        S_NEW,
        S_ALLOC,
        S_WRITE,
        S_UNLINK,
        S_PUSH,
        S_RESP
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [chm_pkg::STATUS_W-1:0] status_reg;
    logic [chm_pkg::STATUS_W-1:0] status_next;
    logic                         miss_insert;

    assign miss_insert = (sts.op == chm_pkg::OP_INSERT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            status_reg <= chm_pkg::STATUS_DONE;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (sts.ignored) begin
                    status_next = chm_pkg::STATUS_IGNORED;
                    state_next  = S_RESP;
                end else if (sts.hash_done) begin
                    cmd.head_rd = 1'b1;
                    state_next  = S_HEAD;
                end else begin
                    cmd.hash_step = 1'b1;
                end
            end
            S_HEAD: begin
                cmd.head_load = 1'b1;
                if (sts.head_ok) begin
                    cmd.ent_rd = 1'b1;
                    cmd.rd_sel = chm_pkg::RD_HEAD;
                    state_next = S_CMP;
                end else if (miss_insert) begin
                    state_next = S_NEW;
                end else begin
                    status_next = chm_pkg::STATUS_MISS;
                    state_next  = S_RESP;
                end
            end
            S_CMP: begin
                if (sts.key_match) begin
                    case (sts.op)
                        chm_pkg::OP_LOOKUP: begin
                            status_next = chm_pkg::STATUS_DONE;
                            state_next  = S_RESP;
                        end
                        chm_pkg::OP_REMOVE: begin
                            state_next = S_UNLINK;
                        end
                        default: begin
                            cmd.update_val = 1'b1;
                            status_next    = chm_pkg::STATUS_DONE;
                            state_next     = S_RESP;
                        end
                    endcase
                end else begin
                    cmd.advance = 1'b1;
                    if (sts.link_ok) begin
                        cmd.ent_rd = 1'b1;
                        cmd.rd_sel = chm_pkg::RD_LINK;
                    end else if (miss_insert) begin
                        state_next = S_NEW;
                    end else begin
                        status_next = chm_pkg::STATUS_MISS;
                        state_next  = S_RESP;
                    end
                end
            end
            S_NEW: begin
                if (sts.free_ok) begin
                    cmd.ent_rd = 1'b1;
                    cmd.rd_sel = chm_pkg::RD_FREE;
                    state_next = S_ALLOC;
                end else if (sts.fresh_ok) begin
                    cmd.alloc_fresh = 1'b1;
                    state_next      = S_WRITE;
                end else begin
                    status_next = chm_pkg::STATUS_FULL;
                    state_next  = S_RESP;
                end
            end
            S_ALLOC: begin
                cmd.alloc_free = 1'b1;
                state_next     = S_WRITE;
            end
            S_WRITE: begin
                cmd.write_new = 1'b1;
                status_next   = chm_pkg::STATUS_DONE;
                state_next    = S_RESP;
            end
            S_UNLINK: begin
                if (sts.prev_ok) begin
                    cmd.unlink_prev = 1'b1;
                end else begin
                    cmd.unlink_head = 1'b1;
                end
                state_next = S_PUSH;
            end
            S_PUSH: begin
                cmd.push_free = 1'b1;
                status_next   = chm_pkg::STATUS_DONE;
                state_next    = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.resp        = 1'b1;
                    cmd.resp_status = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/chained_hash_map_with_free_list.sv =====
// sequence: accept in idle, hash the key, read the bucket head, compare each chain entry
//   visited, then any list update and the result beat; an ignored beat goes straight
//   to the result; hashing takes a byte at a time if BUCKET_COUNT is not a power of two
// throughput: one operation at a time; the result beat stalls while m_valid waits on m_ready
// reset: bucket heads are swept to empty, one per cycle, before the first beat
//   is taken; entry memories are not cleared
// ----------------------------------------------------------------------------
// chained_hash_map_with_free_list
// Key to value map in a fixed entry pool chained from hashed bucket heads,
// with removed entries recycled through a free list.
// ----------------------------------------------------------------------------
module chained_hash_map_with_free_list #(
    parameter int BUCKET_COUNT = 256,
    parameter int POOL_ENTRIES = 1024,
    parameter int KEY_BITS     = 48,
    parameter int VALUE_BITS   = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [chm_pkg::OP_W-1:0]      s_operation,
    input  logic [KEY_BITS-1:0]           s_key,
    input  logic [VALUE_BITS-1:0]         s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [chm_pkg::STATUS_W-1:0]  m_status,
    output logic [VALUE_BITS-1:0]         m_found_value
);

    chm_pkg::cmd_t cmd;
    chm_pkg::sts_t sts;

    chm_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    chm_datapath #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .POOL_ENTRIES (POOL_ENTRIES),
        .KEY_BITS     (KEY_BITS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_operation   (s_operation),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value)
    );

endmodule
